/* hw/rtl/pcxrle_pkg.sv */
// ----------------------------------------------------------------------------
// pcxrle_pkg
// Types and constants shared by the PCX run-length scan line encoder.
// ----------------------------------------------------------------------------
package pcxrle_pkg;

   localparam logic [7:0]  COUNT_TAG         = 8'hC0;
   localparam logic [5:0]  RUN_MAX           = 6'd63;
   localparam logic [7:0]  LITERAL_LIMIT     = 8'd64;
   localparam logic [15:0] LINE_LENGTH_RESET = 16'd640;
   localparam int          LINE_LENGTH_WIDTH = 16;
   localparam int          QUEUE_DEPTH       = 4;
   localparam int          QUEUE_PTR_WIDTH   = 2;

   // one closed run
   typedef struct packed {
      logic       valid;
      logic [7:0] value;
      logic [5:0] length;
      logic       line_end;
   } run_type;

   // runs closed by one pixel: the previous run, then the pixel's own run
   typedef struct packed {
      run_type prev;
      run_type cur;
   } burst_type;

   // output word slots of one burst, in order
   typedef enum logic [1:0] {
      SLOT_PREV_COUNT = 2'd0,
      SLOT_PREV_VALUE = 2'd1,
      SLOT_CUR_COUNT  = 2'd2,
      SLOT_CUR_VALUE  = 2'd3
   } slot_type;

   function automatic logic needs_count(run_type r);
      return (r.length > 6'd1) || (r.value >= LITERAL_LIMIT);
   endfunction

   function automatic logic [7:0] count_word(run_type r);
      return COUNT_TAG | {2'b00, r.length};
   endfunction

endpackage

/* hw/rtl/pcxrle_front.sv */
// ----------------------------------------------------------------------------
// pcxrle_front
// Takes pixels, tracks run and line position, and posts the runs each pixel
// closes as one burst record.
// ----------------------------------------------------------------------------
module pcxrle_front #(
   parameter int POSITION_WIDTH = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_push,
   output logic                   req_full,
   input  logic [7:0]             req_pixel,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [15:0]            csr_wdata,
   input  logic                   queue_full,
   output logic                   burst_push,
   output pcxrle_pkg::burst_type  burst
);
   import pcxrle_pkg::*;

   localparam int CMP_WIDTH = LINE_LENGTH_WIDTH + 1;

   logic [LINE_LENGTH_WIDTH-1:0] line_length_ff;
   logic [7:0]                   run_value_ff;
   logic [7:0]                   run_value_in;
   logic [5:0]                   run_length_ff;
   logic [5:0]                   run_length_in;
   logic [POSITION_WIDTH-1:0]    position_ff;
   logic [POSITION_WIDTH-1:0]    position_in;

   logic                 accept;
   logic                 close_prev;
   logic                 start;
   logic [7:0]           grown_value;
   logic [5:0]           grown_length;
   logic [CMP_WIDTH-1:0] pos_inc;
   logic                 last;
   logic                 cur_close;

   assign csr_ready = 1'b1;
   assign req_full  = queue_full;
   assign accept    = req_push && !queue_full;

   always_comb begin
      close_prev   = (run_length_ff != 6'd0) && (req_pixel != run_value_ff);
      start        = (run_length_ff == 6'd0) || close_prev;
      grown_value  = start ? req_pixel : run_value_ff;
      grown_length = start ? 6'd1 : run_length_ff + 6'd1;
      pos_inc      = CMP_WIDTH'(position_ff) + CMP_WIDTH'(1);
      last         = (&position_ff) || (pos_inc >= CMP_WIDTH'(line_length_ff));
      cur_close    = last || (grown_length >= RUN_MAX);

      burst.prev.valid    = close_prev;
      burst.prev.value    = run_value_ff;
      burst.prev.length   = run_length_ff;
      burst.prev.line_end = 1'b0;
      burst.cur.valid     = cur_close;
      burst.cur.value     = grown_value;
      burst.cur.length    = grown_length;
      burst.cur.line_end  = last;
      burst_push          = accept && (close_prev || cur_close);

      run_value_in  = grown_value;
      run_length_in = cur_close ? 6'd0 : grown_length;
      position_in   = last ? '0 : pos_inc[POSITION_WIDTH-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         line_length_ff <= LINE_LENGTH_RESET;
         run_value_ff   <= 8'd0;
         run_length_ff  <= 6'd0;
         position_ff    <= '0;
      end else begin
         if (csr_valid) begin
            line_length_ff <= csr_wdata;
         end
         if (accept) begin
            run_value_ff  <= run_value_in;
            run_length_ff <= run_length_in;
            position_ff   <= position_in;
         end
      end
   end

endmodule

/* hw/rtl/pcxrle_queue.sv */
// ----------------------------------------------------------------------------
// pcxrle_queue
// Short first-in first-out queue of burst records between front and back.
// ----------------------------------------------------------------------------
module pcxrle_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  pcxrle_pkg::burst_type push_data,
   output logic                  full,
   input  logic                  pop,
   output logic                  empty,
   output pcxrle_pkg::burst_type head
);
   import pcxrle_pkg::*;

   burst_type                   slots_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_WIDTH-1:0]  wr_ptr_ff;
   logic [QUEUE_PTR_WIDTH-1:0]  rd_ptr_ff;
   logic [QUEUE_PTR_WIDTH:0]    count_ff;
   logic [QUEUE_PTR_WIDTH:0]    count_in;
   logic                        do_push;
   logic                        do_pop;

   assign full    = (count_ff == (QUEUE_PTR_WIDTH+1)'(QUEUE_DEPTH));
   assign empty   = (count_ff == '0);
   assign head    = slots_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;

   always_comb begin
      count_in = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slots_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         count_ff <= count_in;
      end
   end

endmodule

/* hw/rtl/pcxrle_back.sv */
// ----------------------------------------------------------------------------
// pcxrle_back
// Expands the head burst record into encoded words and writes them into the
// output register, one per cycle while that register is free.
// ----------------------------------------------------------------------------
module pcxrle_back (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  queue_empty,
   input  pcxrle_pkg::burst_type head,
   output logic                  queue_pop,
   output logic                  rsp_empty,
   input  logic                  rsp_pop,
   output logic [7:0]            rsp_code_byte,
   output logic                  rsp_line_end,
   output logic                  rsp_burst_end
);
   import pcxrle_pkg::*;

   slot_type   phase_ff;
   slot_type   phase_in;
   logic       out_valid_ff;
   logic       out_valid_in;
   logic [7:0] code_ff;
   logic [7:0] code_in;
   logic       line_end_ff;
   logic       line_end_in;
   logic       burst_end_ff;
   logic       burst_end_in;

   logic [3:0] present;
   logic [3:0] eligible;
   logic [3:0] remaining;
   slot_type   sel;
   logic       last;
   logic       out_free;
   logic       advance;

   always_comb begin
      present[SLOT_PREV_COUNT] = head.prev.valid && needs_count(head.prev);
      present[SLOT_PREV_VALUE] = head.prev.valid;
      present[SLOT_CUR_COUNT]  = head.cur.valid && needs_count(head.cur);
      present[SLOT_CUR_VALUE]  = head.cur.valid;
      eligible = present & (4'b1111 << phase_ff);

      sel = SLOT_CUR_VALUE;
      for (int i = 3; i >= 0; i--) begin
         if (eligible[i]) begin
            sel = slot_type'(2'(i));
         end
      end
      remaining = eligible >> sel;
      last      = (remaining[3:1] == 3'b000);

      case (sel)
         SLOT_PREV_COUNT: code_in = count_word(head.prev);
         SLOT_PREV_VALUE: code_in = head.prev.value;
         SLOT_CUR_COUNT:  code_in = count_word(head.cur);
         SLOT_CUR_VALUE:  code_in = head.cur.value;
         default:         code_in = head.cur.value;
      endcase
      line_end_in  = (sel == SLOT_CUR_VALUE) && head.cur.line_end;
      burst_end_in = last;

      out_free  = !out_valid_ff || rsp_pop;
      advance   = !queue_empty && out_free;
      queue_pop = advance && last;

      out_valid_in = advance || (out_valid_ff && !rsp_pop);
      phase_in     = phase_ff;
      if (advance) begin
         phase_in = last ? SLOT_PREV_COUNT : slot_type'(sel + 2'd1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= SLOT_PREV_COUNT;
         out_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         code_ff      <= code_in;
         line_end_ff  <= line_end_in;
         burst_end_ff <= burst_end_in;
      end
   end

   assign rsp_empty     = !out_valid_ff;
   assign rsp_code_byte = code_ff;
   assign rsp_line_end  = line_end_ff;
   assign rsp_burst_end = burst_end_ff;

endmodule

/* hw/rtl/pcx_rle_scanline_encoder_unit.sv */
// ----------------------------------------------------------------------------
// pcx_rle_scanline_encoder_unit
// PCX run-length encoder for raw scan line bytes.
// ----------------------------------------------------------------------------
// Pixels enter on req_ (push/full), encoded words leave on rsp_ (empty/pop),
// one word per pop. rsp_line_end marks the last word of a scan line and
// rsp_burst_end the last word caused by one pixel. csr_ sets the line length
// in pixels; ready is always high, write it only while the block is idle.
// A pixel that closes a run has its first word pass through the queue and the
// output register before it shows on rsp_. Pixels that only extend a run
// produce nothing and are taken one per cycle while req_full is low. The back
// end sends one word per cycle while its output register is free; a pixel
// yields one or two words typically, up to four when it closes two runs. A
// four-entry queue of burst records sits between pixel intake and word output;
// req_full rises when that queue fills, either while the receiver holds off
// popping or when pixels yield words faster than one per cycle. A word stays
// on rsp_ until popped. Reset clears the run, the line position and the
// queue, and sets the line length to 640; no words are pending after reset.
// ----------------------------------------------------------------------------
module pcx_rle_scanline_encoder_unit #(
   parameter int POSITION_WIDTH = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   output logic        req_full,
   input  logic [7:0]  req_pixel,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic [7:0]  rsp_code_byte,
   output logic        rsp_line_end,
   output logic        rsp_burst_end,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [15:0] csr_wdata
);
   import pcxrle_pkg::*;

   logic      burst_push;
   burst_type burst;
   logic      queue_full;
   logic      queue_empty;
   logic      queue_pop;
   burst_type head;

   pcxrle_front #(
      .POSITION_WIDTH(POSITION_WIDTH)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_push   (req_push),
      .req_full   (req_full),
      .req_pixel  (req_pixel),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_wdata  (csr_wdata),
      .queue_full (queue_full),
      .burst_push (burst_push),
      .burst      (burst)
   );

   pcxrle_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (burst_push),
      .push_data (burst),
      .full      (queue_full),
      .pop       (queue_pop),
      .empty     (queue_empty),
      .head      (head)
   );

   pcxrle_back u_back (
      .clock         (clock),
      .reset         (reset),
      .queue_empty   (queue_empty),
      .head          (head),
      .queue_pop     (queue_pop),
      .rsp_empty     (rsp_empty),
      .rsp_pop       (rsp_pop),
      .rsp_code_byte (rsp_code_byte),
      .rsp_line_end  (rsp_line_end),
      .rsp_burst_end (rsp_burst_end)
   );

endmodule

/* hw/rtl/pcxrle_checker.sv */
// ----------------------------------------------------------------------------
// pcxrle_checker
// Port-level checks on the encoder, bound to the top level.
// ----------------------------------------------------------------------------
module pcxrle_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_full,
   input logic        rsp_empty,
   input logic        rsp_pop,
   input logic [7:0]  rsp_code_byte,
   input logic        rsp_line_end,
   input logic        rsp_burst_end
);

   // a waiting word holds until popped
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && !rsp_pop |=> !rsp_empty && $stable(rsp_code_byte)
         && $stable(rsp_line_end) && $stable(rsp_burst_end))
      else $error("rsp word changed while waiting");

   // line end always closes the pixel's burst
   a_line_end_burst: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && rsp_line_end |-> rsp_burst_end)
      else $error("line end without burst end");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> rsp_empty)
      else $error("words pending after reset");

   a_reset_ready: assert property (@(posedge clock)
      reset |=> !req_full)
      else $error("input full after reset");

endmodule

bind pcx_rle_scanline_encoder_unit pcxrle_checker u_pcxrle_checker (
   .clock         (clock),
   .reset         (reset),
   .req_full      (req_full),
   .rsp_empty     (rsp_empty),
   .rsp_pop       (rsp_pop),
   .rsp_code_byte (rsp_code_byte),
   .rsp_line_end  (rsp_line_end),
   .rsp_burst_end (rsp_burst_end)
);
